// ----- sv/x86_branch_target_converter_unit_defines.svh -----
// Assertion macros for the x86 branch target converter.
`ifndef X86_BRANCH_TARGET_CONVERTER_UNIT_DEFINES_SVH
`define X86_BRANCH_TARGET_CONVERTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define BCJC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define BCJC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BCJC_ASSERT_IMPLY(label, ante, cons, msg)

`define BCJC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/bcjc_pkg.sv -----
// Types, opcodes and helper functions shared by the branch converter modules.
package bcjc_pkg;

  localparam logic [7:0] OpCall     = 8'hE8;
  localparam logic [7:0] OpJump     = 8'hE9;
  localparam logic [7:0] OpEscape   = 8'h0F;
  localparam logic [7:0] CondMask   = 8'hF0;
  localparam logic [7:0] CondCode   = 8'h80;
  localparam logic [7:0] BranchMask = 8'hFE;

  localparam logic [8:0] CtxJump = 9'd256;
  localparam logic [8:0] CtxCond = 9'd257;

  localparam logic [1:0] KindMain   = 2'd0;
  localparam logic [1:0] KindStatus = 2'd1;
  localparam logic [1:0] KindCall   = 2'd2;
  localparam logic [1:0] KindJump   = 2'd3;

  localparam logic [1:0] PhMain = 2'd0;
  localparam logic [1:0] PhStat = 2'd1;
  localparam logic [1:0] PhTgt  = 2'd2;

  localparam int NumSlots = 5;
  localparam logic [2:0] LastSlot = 3'd4;

  // slot 0 is the examined head byte, slots 1..4 the tail flushed at image end
  typedef struct packed {
    logic [NumSlots-1:0]       slot_vld;
    logic [NumSlots-1:0][7:0]  slot_op;
    logic [NumSlots-1:0]       slot_stat;
    logic [NumSlots-1:0][8:0]  slot_ctx;
    logic                      conv;
    logic                      is_call;
    logic [31:0]               target;
    logic                      eoi;
  } job_t;

  function automatic logic is_cond(input logic [7:0] prev, input logic [7:0] op);
    return (prev == OpEscape) && ((op & CondMask) == CondCode);
  endfunction

  function automatic logic [8:0] ctx_of(input logic [7:0] prev, input logic [7:0] op);
    logic [8:0] ctx;
    if (op == OpCall) begin
      ctx = {1'b0, prev};
    end else if (op == OpJump) begin
      ctx = CtxJump;
    end else begin
      ctx = CtxCond;
    end
    return ctx;
  endfunction

endpackage

// ----- sv/bcjc_core.sv -----
// Lookahead window, position tracking and per-byte branch decision.
module bcjc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic [31:0]       image_length,
  output bcjc_pkg::job_t    job,
  output logic              job_vld
);
  import bcjc_pkg::*;

  localparam int LookDepth = 4;
  localparam int OpLen     = 5;

  logic [3:0][7:0] la_r, la_nxt, la_w;
  logic [2:0]      fill_r, fill_nxt, fill_w, last_idx;
  logic [7:0]      prior_r, prior_nxt, prior_w;
  logic [31:0]     pos_r, pos_nxt;

  logic        ignore, head_vld, is_br, conv, final_beat;
  logic [7:0]  op;
  logic [31:0] src;
  logic [32:0] dst;
  logic [3:0]  tvld;
  logic [7:0]  prev_b;

  always_comb begin
    ignore   = pos_r >= image_length;
    head_vld = !ignore && fill_r[2];
    op       = la_r[0];
    is_br    = ((op & BranchMask) == OpCall) || is_cond(prior_r, op);
    src      = {data_byte, la_r[3], la_r[2], la_r[1]};
    dst      = {1'b0, pos_r} + {1'b0, src} + 33'(OpLen - LookDepth);
    conv     = is_br && (dst < {1'b0, image_length});

    la_w    = la_r;
    fill_w  = fill_r;
    prior_w = prior_r;
    if (fill_r[2]) begin
      if (conv) begin
        fill_w  = 3'd0;
        prior_w = data_byte;
      end else begin
        la_w    = {data_byte, la_r[3], la_r[2], la_r[1]};
        prior_w = op;
      end
    end else begin
      la_w[fill_r[1:0]] = data_byte;
      fill_w            = fill_r + 3'd1;
    end

    pos_nxt    = pos_r + 32'd1;
    final_beat = !ignore && (pos_nxt == image_length);
    last_idx   = fill_w - 3'd1;

    job          = '0;
    job.slot_vld[0]  = head_vld;
    job.slot_op[0]   = op;
    job.slot_stat[0] = is_br;
    job.slot_ctx[0]  = ctx_of(prior_r, op);
    job.conv         = conv;
    job.is_call      = (op == OpCall);
    job.target       = dst[31:0];
    job.eoi          = final_beat;
    for (int i = 0; i < LookDepth; i++) begin
      tvld[i] = final_beat && (i < int'(fill_w));
      prev_b  = (i == 0) ? prior_w : la_w[(i == 0) ? 0 : i - 1];
      job.slot_vld[i+1]  = tvld[i];
      job.slot_op[i+1]   = la_w[i];
      job.slot_stat[i+1] = (la_w[i] == OpCall) || (la_w[i] == OpJump) ||
                           is_cond(prev_b, la_w[i]);
      job.slot_ctx[i+1]  = ctx_of(prev_b, la_w[i]);
    end
    job_vld = |job.slot_vld;

    la_nxt    = la_w;
    fill_nxt  = fill_w;
    prior_nxt = prior_w;
    if (final_beat) begin
      fill_nxt = 3'd0;
      if (fill_w != 3'd0) begin
        prior_nxt = la_w[last_idx[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r    <= '0;
      fill_r  <= '0;
      prior_r <= '0;
      pos_r   <= '0;
    end else if (fire && !ignore) begin
      la_r    <= la_nxt;
      fill_r  <= fill_nxt;
      prior_r <= prior_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ----- sv/bcjc_emit.sv -----
// Result sequencer: walks one job's slots and feeds the output register.
module bcjc_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_load,
  input  bcjc_pkg::job_t    job_in,
  output logic              job_take,
  output logic              busy,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [1:0]        out_stream_kind,
  output logic [31:0]       out_value,
  output logic [8:0]        out_context_index,
  output logic              out_last_of_run,
  output logic              out_end_of_image
);
  import bcjc_pkg::*;

  job_t        job_r;
  logic        job_vld_r, job_vld_nxt;
  logic [2:0]  slot_r, slot_nxt, slot_inc;
  logic [1:0]  phase_r, phase_nxt;

  logic        out_vld_r, out_vld_nxt;
  logic [1:0]  kind_r, kind_c;
  logic [31:0] value_r, value_c;
  logic [8:0]  ctx_r, ctx_c;
  logic        last_r, eoi_r;

  logic        issue, more, has_next, job_last;
  logic [7:0]  mask_ext;

  always_comb begin
    issue    = job_vld_r && (!out_vld_r || !out_stall);
    slot_inc = slot_r + 3'd1;
    mask_ext = {3'b000, job_r.slot_vld};
    has_next = (slot_r != LastSlot) && mask_ext[slot_inc];

    case (phase_r)
      PhMain: begin
        kind_c  = KindMain;
        value_c = {24'd0, job_r.slot_op[slot_r]};
        ctx_c   = '0;
        more    = job_r.slot_stat[slot_r];
      end
      PhStat: begin
        kind_c  = KindStatus;
        value_c = {31'd0, (slot_r == 3'd0) && job_r.conv};
        ctx_c   = job_r.slot_ctx[slot_r];
        more    = (slot_r == 3'd0) && job_r.conv;
      end
      PhTgt: begin
        kind_c  = job_r.is_call ? KindCall : KindJump;
        value_c = job_r.target;
        ctx_c   = '0;
        more    = 1'b0;
      end
      default: begin
        kind_c  = KindMain;
        value_c = '0;
        ctx_c   = '0;
        more    = 1'b0;
      end
    endcase

    job_last = !more && !has_next;
    job_take = !job_vld_r || (issue && job_last);
    busy     = job_vld_r;

    job_vld_nxt = job_vld_r;
    slot_nxt    = slot_r;
    phase_nxt   = phase_r;
    if (job_load) begin
      job_vld_nxt = 1'b1;
      slot_nxt    = job_in.slot_vld[0] ? 3'd0 : 3'd1;
      phase_nxt   = PhMain;
    end else if (issue) begin
      if (more) begin
        phase_nxt = (phase_r == PhMain) ? PhStat : PhTgt;
      end else if (has_next) begin
        slot_nxt  = slot_inc;
        phase_nxt = PhMain;
      end else begin
        job_vld_nxt = 1'b0;
      end
    end

    out_vld_nxt = issue ? 1'b1 : (out_stall ? out_vld_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      slot_r    <= '0;
      phase_r   <= PhMain;
      out_vld_r <= 1'b0;
    end else begin
      job_vld_r <= job_vld_nxt;
      slot_r    <= slot_nxt;
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
    if (issue) begin
      kind_r  <= kind_c;
      value_r <= value_c;
      ctx_r   <= ctx_c;
      last_r  <= job_last;
      eoi_r   <= job_last && job_r.eoi;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_stream_kind   = kind_r;
  assign out_value         = value_r;
  assign out_context_index = ctx_r;
  assign out_last_of_run   = last_r;
  assign out_end_of_image  = eoi_r;

endmodule

// ----- sv/x86_branch_target_converter_unit.sv -----
// Top level of the x86 branch target converter (status/call/jump split).
//
// Write the image length through cfg_wr_en/cfg_wr_data while idle, then send
// the image one byte per beat on in_valid/in_data_byte. Each accepted byte
// yields 0 to 10 result beats on out_*: main bytes, status decisions with
// their context, and converted call or jump targets. out_last_of_run marks the
// final beat caused by one input byte, out_end_of_image the final beat of the
// image. Bytes beyond the programmed length are taken and dropped.
// The first result beat of a byte passes through the job register and then
// the output register before it is valid on out_*. Throughput: one result
// beat per cycle while out_stall is low; a byte is taken in the cycle its
// predecessor's last result beat is issued. The one-beat sequencer sets this
// rate.
// Reset clears the window, position, prior byte, length and both valids.
// While out_stall is high the output beat holds and in_stall rises once the
// pending job can no longer advance.
module x86_branch_target_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_stream_kind,
  output logic [31:0] out_value,
  output logic [8:0]  out_context_index,
  output logic        out_last_of_run,
  output logic        out_end_of_image
);
  import bcjc_pkg::*;

  `include "x86_branch_target_converter_unit_defines.svh"

  logic [31:0] image_length_r;
  logic        in_fire, job_take, job_vld, busy;
  logic        zero_take, tgt_beat;
  job_t        job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_length_r <= '0;
    end else if (cfg_wr_en) begin
      image_length_r <= cfg_wr_data;
    end
  end

  assign in_stall = !job_take;
  assign in_fire  = in_valid && !in_stall;

  bcjc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .data_byte    (in_data_byte),
    .image_length (image_length_r),
    .job          (job),
    .job_vld      (job_vld)
  );

  bcjc_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_load          (in_fire && job_vld),
    .job_in            (job),
    .job_take          (job_take),
    .busy              (busy),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_stream_kind   (out_stream_kind),
    .out_value         (out_value),
    .out_context_index (out_context_index),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_image  (out_end_of_image)
  );

  assign zero_take = out_valid && !out_stall && (out_stream_kind == KindStatus) &&
                     (out_value == 32'd0);
  assign tgt_beat  = out_valid && ((out_stream_kind == KindCall) ||
                                   (out_stream_kind == KindJump));

  `BCJC_ASSERT_IMPLY(a_eoi_is_last, out_valid && out_end_of_image, out_last_of_run, "eoi not last")
  `BCJC_ASSERT_IMPLY(a_idle_no_stall, !busy, !in_stall, "input stalled while idle")
  `BCJC_ASSERT_IMPLY(a_ctx_range, out_valid, out_context_index <= CtxCond, "context out of range")
  `BCJC_ASSERT_NEXT(a_no_target_after_zero, zero_take, !tgt_beat, "target after status 0")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for x86_branch_target_converter_unit with a predicting scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bcjc_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [8:0]  ctx;
    logic        run_end;
    logic        image_end;
  } beat_t;

  class split_scoreboard;
    logic [31:0] image_len;
    logic [7:0]  window [4];
    int unsigned fill;
    logic [7:0]  prior;
    logic [31:0] position;
    int unsigned in_image;
    int unsigned errors;
    beat_t       run_beats[$];
    beat_t       expected_beats[$];

    function new();
      image_len = '0;
      fill = 0;
      prior = '0;
      position = '0;
      in_image = 0;
      errors = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_length(logic [31:0] len);
      image_len = len;
    endfunction

    function bit is_jcc(logic [7:0] prev, logic [7:0] op);
      return (prev == OpEscape) && ((op & CondMask) == CondCode);
    endfunction

    function logic [8:0] status_ctx(logic [7:0] prev, logic [7:0] op);
      if (op == OpCall) return {1'b0, prev};
      if (op == OpJump) return CtxJump;
      return CtxCond;
    endfunction

    function void add(logic [1:0] kind, logic [31:0] value, logic [8:0] ctx);
      beat_t bt;
      bt.kind = kind;
      bt.value = value;
      bt.ctx = ctx;
      bt.run_end = 1'b0;
      bt.image_end = 1'b0;
      run_beats.push_back(bt);
    endfunction

    // predicts the beats caused by one accepted byte
    function void take_byte(logic [7:0] b);
      logic [7:0]  op;
      logic [31:0] offs;
      logic [63:0] dst;
      logic [8:0]  ctx;
      beat_t       tail;
      int          i;
      if (position >= image_len) return;
      in_image++;
      run_beats.delete();
      if (fill >= 4) begin
        op = window[0];
        add(KindMain, {24'd0, op}, '0);
        if (((op & BranchMask) == OpCall) || is_jcc(prior, op)) begin
          offs = {b, window[3], window[2], window[1]};
          dst = {32'd0, position} - 64'd4 + {32'd0, offs} + 64'd5;
          ctx = status_ctx(prior, op);
          if (dst < {32'd0, image_len}) begin
            add(KindStatus, 32'd1, ctx);
            add((op == OpCall) ? KindCall : KindJump, dst[31:0], '0);
            prior = b;
            fill = 0;
          end else begin
            add(KindStatus, 32'd0, ctx);
            prior = op;
          end
        end else begin
          prior = op;
        end
        if (fill != 0) begin
          window[0] = window[1];
          window[1] = window[2];
          window[2] = window[3];
          window[3] = b;
        end
      end else begin
        window[fill] = b;
        fill++;
      end
      position++;
      if (position == image_len) begin
        for (i = 0; i < fill; i++) begin
          op = window[i];
          add(KindMain, {24'd0, op}, '0);
          if (op == OpCall || op == OpJump || is_jcc(prior, op))
            add(KindStatus, 32'd0, status_ctx(prior, op));
          prior = op;
        end
        fill = 0;
        if (run_beats.size() > 0) begin
          tail = run_beats.pop_back();
          tail.image_end = 1'b1;
          run_beats.push_back(tail);
        end
      end
      if (run_beats.size() > 0) begin
        tail = run_beats.pop_back();
        tail.run_end = 1'b1;
        run_beats.push_back(tail);
      end
      foreach (run_beats[k]) expected_beats.push_back(run_beats[k]);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got kind %0d value %0h ctx %0d",
                 $time, got.kind, got.value, got.ctx);
        return;
      end
      want = expected_beats.pop_front();
      cmp("stream_kind", 32'(want.kind), 32'(got.kind));
      cmp("value", want.value, got.value);
      cmp("context_index", 32'(want.ctx), 32'(got.ctx));
      cmp("last_of_run", 32'(want.run_end), 32'(got.run_end));
      cmp("end_of_image", 32'(want.image_end), 32'(got.image_end));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_stream_kind;
  logic [31:0] out_value;
  logic [8:0]  out_context_index;
  logic        out_last_of_run;
  logic        out_end_of_image;

  split_scoreboard board;
  int              send_pct;
  int              stall_pct;

  x86_branch_target_converter_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stream_kind   (out_stream_kind),
    .out_value         (out_value),
    .out_context_index (out_context_index),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_image  (out_end_of_image)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    beat_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.kind = out_stream_kind;
      seen.value = out_value;
      seen.ctx = out_context_index;
      seen.run_end = out_last_of_run;
      seen.image_end = out_end_of_image;
      board.check_beat(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(b);
  endtask

  // length is only written once all beats are out and the block has settled
  task automatic write_length(input logic [31:0] len);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    board.set_length(len);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly branch opcodes with offsets aimed inside the image, plus noise
  function automatic void build_image(input logic [31:0] base, input int n,
                                      ref logic [7:0] img[$]);
    logic [31:0] at;
    logic [31:0] offs;
    logic [31:0] dest;
    int          sel;
    int          k;
    img.delete();
    while (img.size() < n) begin
      if ($urandom_range(0, 99) < 45) begin
        sel = $urandom_range(0, 2);
        if (sel == 2) begin
          img.push_back(OpEscape);
          img.push_back(CondCode | {4'd0, 4'($urandom_range(0, 15))});
        end else begin
          img.push_back((sel == 0) ? OpCall : OpJump);
        end
        at = base + img.size() - 1;
        sel = $urandom_range(0, 7);
        if (sel <= 4) begin
          dest = base + $urandom_range(0, n - 1);
          offs = dest - at - 32'd5;
        end else if (sel == 5) begin
          dest = base + n + $urandom_range(0, 2);
          offs = dest - at - 32'd5;
        end else begin
          offs = $urandom();
        end
        for (k = 0; k < 4; k++) img.push_back(offs[8*k +: 8]);
      end else begin
        img.push_back(8'($urandom()));
      end
    end
    while (img.size() > n) void'(img.pop_back());
  endfunction

  initial begin
    logic [7:0]  img[$];
    logic [31:0] base;
    int          n;
    int          cut;
    int          phase;
    int          sel;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    send_pct = 0;
    stall_pct = 0;
    board = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty image: bytes dropped
    write_length(32'd0);
    send_byte(OpCall);
    send_byte(8'hFF);
    // short images, tail rule only
    write_length(board.position + 1);
    send_byte(OpCall);
    write_length(board.position + 3);
    send_byte(OpEscape);
    send_byte(CondCode | 8'h05);
    send_byte(OpJump);
    // converted jcc, out-of-range jmp, call landing exactly on the end
    write_length(board.position + 16);
    img = '{OpEscape, CondCode, 8'h02, 8'h00, 8'h00, 8'h00,
            OpJump, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
            OpCall, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (img[i]) send_byte(img[i]);
    // length cut below the position mid-image
    write_length(board.position + 8);
    send_byte(OpCall);
    send_byte(8'h11);
    send_byte(8'h22);
    write_length(board.position - 1);
    send_byte(OpJump);

    phase = 0;
    while (board.in_image < 380) begin
      send_pct = (phase % 4 == 1) ? 45 : (phase % 4 == 3) ? 15 : 0;
      stall_pct = (phase % 4 == 2) ? 45 : (phase % 4 == 3) ? 15 : 0;
      sel = $urandom_range(0, 9);
      n = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(1, 4) : $urandom_range(5, 48);
      base = board.position;
      write_length(base + n);
      build_image(base, n, img);
      cut = n;
      if (n > 6 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, n - 1);
      for (int i = 0; i < cut; i++) send_byte(img[i]);
      if (cut < n) write_length(board.position - $urandom_range(0, 2));
      if (n == 0 || cut < n || $urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom()));
      phase++;
    end

    // open-ended image at the largest length
    send_pct = 15;
    stall_pct = 15;
    write_length(32'hFFFF_FFFF);
    build_image(board.position, 40, img);
    foreach (img[i]) send_byte(img[i]);
    @(negedge clk);
    in_valid <= 1'b0;

    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
